>>> sv/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// shared types and constants of the bitmap run allocator
// ----------------------------------------------------------------------------
package bra_pkg;

    // pool geometry
    localparam int SLOTS   = 1024;
    localparam int WORD_W  = 32;
    localparam int WORDS   = SLOTS / WORD_W;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WADDR_W = $clog2(WORDS);
    localparam int TCNT_W  = BIT_W + 1;

    // request codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] run_length;
        logic [IDX_W-1:0] start_index;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] run_start;
        logic [CNT_W-1:0] free_units;
    } t_rsp;

endpackage

>>> sv/bitmap_run_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_top
// first-fit allocator of contiguous runs over an occupancy bitmap held in a
// word-wide synchronous ram, with a free-unit counter
// ----------------------------------------------------------------------------
//
//  channel   valid         ready         payload            transfer moves
//  request   i_in_valid    o_in_ready    i_in_data  (t_req)  alloc / release
//  result    o_out_valid   i_out_ready   o_out_data (t_rsp)  one per request
//
//  a request is taken only while the engine is idle; its result goes into an
//  output register, so the next request is taken while that result waits
//  allocate: map words are scanned in order until a run fits (up to 32 words), then
//  each word of the run is marked (up to 32), paced by the single read port of the map ram
//  release: each word of the run is cleared (up to 32); refused or empty requests skip
//  the map. after reset the whole map reads free through per-word valid bits, so no
//  clearing pass is run; a stalled result only holds the engine in its end state
//
module bitmap_run_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bra_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bra_pkg::t_rsp o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MARK,
        S_FIN
    } t_state;

    // occupancy map ram, one bit per unit, busy = 1
    logic [bra_pkg::WORD_W-1:0] r_map_mem [0:bra_pkg::WORDS-1];
    logic [bra_pkg::WORDS-1:0]  r_row_valid;
    logic [bra_pkg::WORD_W-1:0] r_rd_data;
    logic                       r_rd_valid;

    // ram port controls
    logic                        rd_en;
    logic [bra_pkg::WADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [bra_pkg::WADDR_W-1:0] wr_addr;
    logic [bra_pkg::WORD_W-1:0]  wr_data;

    // engine state
    t_state                      r_state,     n_state;
    logic [bra_pkg::CNT_W-1:0]   r_len,       n_len;
    logic [bra_pkg::CNT_W-1:0]   r_free,      n_free;
    logic [bra_pkg::WADDR_W-1:0] r_word,      n_word;
    logic [bra_pkg::CNT_W-1:0]   r_cur_run,   n_cur_run;
    logic [bra_pkg::IDX_W-1:0]   r_start,     n_start;
    logic [bra_pkg::IDX_W-1:0]   r_lo,        n_lo;
    logic [bra_pkg::IDX_W-1:0]   r_hi,        n_hi;
    logic                        r_set,       n_set;
    logic [bra_pkg::WADDR_W-1:0] r_mark_word, n_mark_word;
    logic                        r_ok,        n_ok;
    logic [bra_pkg::IDX_W-1:0]   r_run_start, n_run_start;
    logic                        r_out_valid, n_out_valid;
    bra_pkg::t_rsp               r_out,       n_out;

    // word under inspection
    logic [bra_pkg::WORD_W-1:0]  word_eff;
    logic [bra_pkg::IDX_W-1:0]   word_base;
    logic [bra_pkg::TCNT_W-1:0]  trail_free;
    logic [bra_pkg::TCNT_W-1:0]  top_free;
    logic [bra_pkg::WORD_W-1:0]  free_span [0:bra_pkg::BIT_W];
    logic [bra_pkg::WORD_W-1:0]  fit_mask;
    logic [bra_pkg::TCNT_W:0]    fit_off;
    logic [bra_pkg::BIT_W-1:0]   fit_idx;
    logic [bra_pkg::CNT_W:0]     prefix_sum;
    logic                        hit_prefix;
    logic                        hit_inner;
    logic                        hit;
    logic [bra_pkg::IDX_W-1:0]   hit_start;
    logic [bra_pkg::CNT_W-1:0]   carry_start;

    // run edits
    logic [bra_pkg::BIT_W-1:0]   lo_bit;
    logic [bra_pkg::BIT_W-1:0]   hi_bit;
    logic [bra_pkg::WORD_W-1:0]  run_mask;
    logic [bra_pkg::CNT_W-1:0]   rel_room;
    logic [bra_pkg::CNT_W-1:0]   rel_clip;
    logic [bra_pkg::CNT_W:0]     rel_sum;
    logic                        in_xfer;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // map ram: one read and one write port, registered read data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_map_mem[rd_addr];
        end
        if (wr_en) begin
            r_map_mem[wr_addr] <= wr_data;
        end
    end

    // a row that was never written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_valid <= r_row_valid[rd_addr];
            end
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
        end
    end

    assign word_eff  = r_rd_valid ? r_rd_data : '0;
    assign word_base = {r_word, bra_pkg::BIT_W'(0)};

    // ------------------------------------------------------------------
    // first-fit step over one word
    // ------------------------------------------------------------------
    always_comb begin
        // free units from bit 0 upwards, and from the top bit downwards
        trail_free = bra_pkg::TCNT_W'(bra_pkg::WORD_W);
        for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
            if (word_eff[i]) begin
                trail_free = bra_pkg::TCNT_W'(i);
            end
        end
        top_free = bra_pkg::TCNT_W'(bra_pkg::WORD_W);
        for (int i = 0; i < bra_pkg::WORD_W; i++) begin
            if (word_eff[i]) begin
                top_free = bra_pkg::TCNT_W'(bra_pkg::WORD_W - 1 - i);
            end
        end

        // free_span[b] bit j: units j .. j+2^b-1 all free inside the word
        free_span[0] = ~word_eff;
        for (int b = 1; b <= bra_pkg::BIT_W; b++) begin
            free_span[b] = free_span[b-1] & (free_span[b-1] >> (1 << (b - 1)));
        end
        // compose a span of exactly the run length
        fit_mask = '1;
        fit_off  = '0;
        for (int b = 0; b <= bra_pkg::BIT_W; b++) begin
            if (r_len[b]) begin
                fit_mask = fit_mask & (free_span[b] >> fit_off);
                fit_off  = fit_off + (bra_pkg::TCNT_W + 1)'(1 << b);
            end
        end
        fit_idx = '0;
        for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
            if (fit_mask[i]) begin
                fit_idx = bra_pkg::BIT_W'(i);
            end
        end

        // run carried in from earlier words completes here
        prefix_sum = (bra_pkg::CNT_W + 1)'(r_cur_run) + (bra_pkg::CNT_W + 1)'(trail_free);
        hit_prefix = prefix_sum >= (bra_pkg::CNT_W + 1)'(r_len);
        // or a short run lies wholly inside this word
        hit_inner  = (r_len <= bra_pkg::CNT_W'(bra_pkg::WORD_W)) && (fit_mask != '0);
        hit        = hit_prefix || hit_inner;
        hit_start  = hit_prefix ? r_start : (word_base + bra_pkg::IDX_W'(fit_idx));
        // start of the free tail that runs into the next word
        carry_start = bra_pkg::CNT_W'(word_base) + bra_pkg::CNT_W'(bra_pkg::WORD_W)
                    - bra_pkg::CNT_W'(top_free);
    end

    // ------------------------------------------------------------------
    // set / clear mask of the run over the word being edited
    // ------------------------------------------------------------------
    always_comb begin
        lo_bit = (r_mark_word == r_lo[bra_pkg::IDX_W-1:bra_pkg::BIT_W])
               ? r_lo[bra_pkg::BIT_W-1:0] : '0;
        hi_bit = (r_mark_word == r_hi[bra_pkg::IDX_W-1:bra_pkg::BIT_W])
               ? r_hi[bra_pkg::BIT_W-1:0] : '1;
        run_mask = ({bra_pkg::WORD_W{1'b1}} << lo_bit)
                 & ({bra_pkg::WORD_W{1'b1}} >> (~hi_bit));
        wr_data  = r_set ? (word_eff | run_mask) : (word_eff & ~run_mask);
    end

    // release clipped at the pool end, credit saturating at the pool size
    always_comb begin
        rel_room = bra_pkg::CNT_W'(bra_pkg::SLOTS) - bra_pkg::CNT_W'(i_in_data.start_index);
        rel_clip = (i_in_data.run_length < rel_room) ? i_in_data.run_length : rel_room;
        rel_sum  = (bra_pkg::CNT_W + 1)'(r_free) + (bra_pkg::CNT_W + 1)'(rel_clip);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_free      = r_free;
        n_word      = r_word;
        n_cur_run   = r_cur_run;
        n_start     = r_start;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_mark_word = r_mark_word;
        n_ok        = r_ok;
        n_run_start = r_run_start;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_mark_word;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_len       = i_in_data.run_length;
                    n_run_start = '0;
                    if (i_in_data.cmd == bra_pkg::CMD_ALLOC) begin
                        if (i_in_data.run_length == '0 || r_free < i_in_data.run_length) begin
                            // refused: zero length, or too few free units on the counter
                            n_ok    = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                            n_word    = '0;
                            n_cur_run = '0;
                            n_start   = '0;
                            n_state   = S_SEARCH;
                        end
                    end else begin
                        n_ok   = 1'b1;
                        n_free = (rel_sum > (bra_pkg::CNT_W + 1)'(bra_pkg::SLOTS))
                               ? bra_pkg::CNT_W'(bra_pkg::SLOTS) : rel_sum[bra_pkg::CNT_W-1:0];
                        if (rel_clip == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_lo        = i_in_data.start_index;
                            n_hi        = i_in_data.start_index
                                        + rel_clip[bra_pkg::IDX_W-1:0] - 1'b1;
                            n_set       = 1'b0;
                            rd_en       = 1'b1;
                            rd_addr     = i_in_data.start_index[bra_pkg::IDX_W-1:bra_pkg::BIT_W];
                            n_mark_word = rd_addr;
                            n_state     = S_MARK;
                        end
                    end
                end
            end

            S_SEARCH: begin
                if (hit) begin
                    n_lo        = hit_start;
                    n_hi        = hit_start + r_len[bra_pkg::IDX_W-1:0] - 1'b1;
                    n_set       = 1'b1;
                    n_ok        = 1'b1;
                    n_run_start = hit_start;
                    n_free      = r_free - r_len;
                    rd_en       = 1'b1;
                    rd_addr     = hit_start[bra_pkg::IDX_W-1:bra_pkg::BIT_W];
                    n_mark_word = rd_addr;
                    n_state     = S_MARK;
                end else if (r_word == bra_pkg::WADDR_W'(bra_pkg::WORDS - 1)) begin
                    // map exhausted, no free run long enough
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_word + 1'b1;
                    n_word  = rd_addr;
                    if (trail_free == bra_pkg::TCNT_W'(bra_pkg::WORD_W)) begin
                        n_cur_run = r_cur_run + bra_pkg::CNT_W'(bra_pkg::WORD_W);
                    end else begin
                        n_cur_run = bra_pkg::CNT_W'(top_free);
                        n_start   = carry_start[bra_pkg::IDX_W-1:0];
                    end
                end
            end

            S_MARK: begin
                // write back this word while the next one is read
                wr_en = 1'b1;
                if (r_mark_word == r_hi[bra_pkg::IDX_W-1:bra_pkg::BIT_W]) begin
                    n_state = S_FIN;
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = r_mark_word + 1'b1;
                    n_mark_word = rd_addr;
                end
            end

            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.ok         = r_ok;
                    n_out.run_start  = r_ok ? r_run_start : '0;
                    n_out.free_units = r_free;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= bra_pkg::CNT_W'(bra_pkg::SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_len       <= n_len;
        r_word      <= n_word;
        r_cur_run   <= n_cur_run;
        r_start     <= n_start;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_mark_word <= n_mark_word;
        r_ok        <= n_ok;
        r_run_start <= n_run_start;
        r_out       <= n_out;
    end

endmodule

>>> sim/bitmap_run_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_top_tb
// self-checking bench for the first-fit run allocator: a local bitmap
// predictor follows every accepted request, and each result is compared
// field by field with the oldest prediction, under random idling on both sides
// ----------------------------------------------------------------------------
module bitmap_run_allocator_top_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 728;
    localparam int MAX_IDLE      = 15;
    localparam int DRAIN_CYCLES  = 80;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int REPORT_MAX    = 10;

    // a prediction together with the request that caused it
    typedef struct {
        bra_pkg::t_req req;
        bra_pkg::t_rsp rsp;
    } t_outcome;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    bra_pkg::t_req req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    bra_pkg::t_rsp rsp_data;

    // stimulus waiting to be driven, predictions waiting for their results
    bra_pkg::t_req request_q[$];
    t_outcome      outcome_q[$];
    // runs handed out by the block, kept so that they can be given back whole
    bra_pkg::t_req held_runs[$];

    // predictor state
    logic [bra_pkg::SLOTS-1:0] busy_map;
    int unsigned               free_cnt;

    bit          no_idle   = 1'b0;
    int          req_gap   = 0;
    int          rsp_stall = 0;
    int          errors    = 0;
    int          n_results = 0;
    int          n_granted = 0;
    int          n_refused = 0;
    int          n_release = 0;
    int unsigned cycle_count = 0;

    bitmap_run_allocator_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    function automatic bra_pkg::t_req make_req(logic cmd, int unsigned len,
                                               int unsigned start);
        bra_pkg::t_req r;
        r.cmd         = cmd;
        r.run_length  = len[bra_pkg::CNT_W-1:0];
        r.start_index = start[bra_pkg::IDX_W-1:0];
        return r;
    endfunction

    // idle cycles before the next transfer; none at all during a burst stretch
    function automatic int idle_draw();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // mostly short runs, some medium, a few up to the whole pool and beyond
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(1, 16);
        else if (sel < 88)
            return $urandom_range(17, 128);
        else if (sel < 97)
            return $urandom_range(129, bra_pkg::SLOTS);
        return $urandom_range(0, (1 << bra_pkg::CNT_W) - 1);
    endfunction

    // applies one request to the local bitmap and counter, returns its result
    function automatic bra_pkg::t_rsp apply_request(bra_pkg::t_req r);
        bra_pkg::t_rsp res;
        int unsigned   len;
        int unsigned   pos;
        int unsigned   u;
        int unsigned   clip;
        bit            found;
        len   = r.run_length;
        found = 1'b0;
        pos   = 0;
        res   = '0;
        if (r.cmd == bra_pkg::CMD_ALLOC) begin
            // zero length and short counter both refuse without a search
            if (len != 0 && free_cnt >= len) begin
                // first fit: on a busy unit, restart just past it
                while (!found && len <= bra_pkg::SLOTS && pos <= bra_pkg::SLOTS - len) begin
                    u = pos;
                    while (u < pos + len && !busy_map[u])
                        u++;
                    if (u == pos + len)
                        found = 1'b1;
                    else
                        pos = u + 1;
                end
            end
            if (found) begin
                for (u = pos; u < pos + len; u++)
                    busy_map[u] = 1'b1;
                free_cnt      = free_cnt - len;
                res.ok        = 1'b1;
                res.run_start = pos[bra_pkg::IDX_W-1:0];
            end
        end else begin
            // clip at the pool end; already-free units are still credited
            clip = bra_pkg::SLOTS - r.start_index;
            if (len < clip)
                clip = len;
            for (u = r.start_index; u < r.start_index + clip; u++)
                busy_map[u] = 1'b0;
            free_cnt = free_cnt + clip;
            if (free_cnt > bra_pkg::SLOTS)
                free_cnt = bra_pkg::SLOTS;
            res.ok = 1'b1;
        end
        res.free_units = free_cnt[bra_pkg::CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: one transfer per queued item, random gap between items
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_requests
        t_outcome pred;
        int       gap_now;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_gap   <= idle_draw();
            busy_map  = '0;
            free_cnt  = bra_pkg::SLOTS;
        end else if (req_valid && req_ready) begin
            // accepted: predict now so that ordering follows the transfers
            pred.req = req_data;
            pred.rsp = apply_request(req_data);
            outcome_q.push_back(pred);
            gap_now = idle_draw();
            if (gap_now == 0 && request_q.size() > 0) begin
                // back-to-back: valid stays high, only the payload moves on
                req_data <= request_q.pop_front();
            end else begin
                req_valid <= 1'b0;
                req_gap   <= gap_now;
            end
        end else if (!req_valid) begin
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
            end else if (request_q.size() > 0) begin
                req_data  <= request_q.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each transfer with the oldest prediction and
    // stalls ready for a random number of cycles after each one
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        t_outcome want;
        int       stall;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_stall <= idle_draw();
        end else if (rsp_valid && rsp_ready) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: ok=%0d start=%0d free=%0d",
                             rsp_data.ok, rsp_data.run_start, rsp_data.free_units);
            end else begin
                want = outcome_q.pop_front();
                if (rsp_data.ok !== want.rsp.ok ||
                    rsp_data.run_start !== want.rsp.run_start ||
                    rsp_data.free_units !== want.rsp.free_units) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("mismatch cmd=%0d len=%0d idx=%0d: ",
                                 want.req.cmd, want.req.run_length, want.req.start_index,
                                 "expected ok=%0d start=%0d free=%0d, ",
                                 want.rsp.ok, want.rsp.run_start, want.rsp.free_units,
                                 "got ok=%0d start=%0d free=%0d",
                                 rsp_data.ok, rsp_data.run_start, rsp_data.free_units);
                end
                // tally and remember granted runs for well-formed releases
                if (want.req.cmd == bra_pkg::CMD_RELEASE) begin
                    n_release++;
                end else if (want.rsp.ok) begin
                    n_granted++;
                    held_runs.push_back(make_req(bra_pkg::CMD_RELEASE, want.req.run_length,
                                                 want.rsp.run_start));
                end else begin
                    n_refused++;
                end
            end
            stall = idle_draw();
            if (stall != 0) begin
                rsp_ready <= 1'b0;
                rsp_stall <= stall;
            end
        end else if (!rsp_ready) begin
            if (rsp_stall > 1)
                rsp_stall <= rsp_stall - 1;
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("run stopped at the cycle limit, %0d results outstanding",
                     outcome_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed corner cases, then random traffic
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          i;
        int unsigned sel;
        int unsigned pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // whole pool in one run, a refusal on the full pool, then release of it all
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   bra_pkg::SLOTS, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, bra_pkg::SLOTS, 0));
        // zero length and longer than the pool
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   0, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   (1 << bra_pkg::CNT_W) - 1,
                                     $urandom()));
        // small runs, one ending exactly at a word boundary
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   bra_pkg::WORD_W - 1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   3, $urandom()));
        // release past the pool end is clipped to the last unit
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, (1 << bra_pkg::CNT_W) - 1,
                                     bra_pkg::SLOTS - 1));
        // empty release, then release of units that are already free
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, 0, 5));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, 100, 1000));
        // punch a one-unit hole, push the counter to saturation
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, 1, 1));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, bra_pkg::SLOTS, 600));
        // counter passes but no free run is long enough
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1000, $urandom()));
        // first fit skips the hole for a long run, then fills it with a short one
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   2, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1, $urandom()));
        // clear everything, then fill the pool so that a run ends exactly at the last unit
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, bra_pkg::SLOTS - 1, 0));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, 1, bra_pkg::SLOTS - 1));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   bra_pkg::SLOTS - 1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, (1 << bra_pkg::CNT_W) - 1, 0));
        // word-sized and just-over-word runs from an empty pool
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   bra_pkg::WORD_W, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_ALLOC,   bra_pkg::WORD_W + 1, $urandom()));
        request_q.push_back(make_req(bra_pkg::CMD_RELEASE, bra_pkg::WORD_W, 0));

        // random part, fed lazily so that granted runs can be given back whole;
        // the generator works on the falling edge to stay clear of the monitor
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            while (request_q.size() > 1)
                @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                no_idle <= ~no_idle;
            sel = $urandom_range(0, 99);
            if (sel < 42 && held_runs.size() > 0) begin
                // well-formed: hand back a run that was granted
                pick = $urandom_range(0, held_runs.size() - 1);
                request_q.push_back(held_runs[pick]);
                held_runs.delete(pick);
            end else if (sel < 55) begin
                // stray release anywhere in the pool
                request_q.push_back(make_req(bra_pkg::CMD_RELEASE, pick_length(),
                                             $urandom_range(0, bra_pkg::SLOTS - 1)));
            end else begin
                request_q.push_back(make_req(bra_pkg::CMD_ALLOC, pick_length(), $urandom()));
            end
        end

        // drain until every prediction has met its result, then run on for DRAIN_CYCLES
        while (request_q.size() != 0 || req_valid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (outcome_q.size() != 0)
            errors++;

        $display("%0d results checked: %0d runs granted, %0d allocates refused, %0d releases",
                 n_results, n_granted, n_refused, n_release);
        $display("%0d mismatches in %0d cycles", errors, cycle_count);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
